>>> hdl/fcirc_pkg.sv
package fcirc_pkg;

    localparam int TAPS      = 16;
    localparam int DATA_W    = 16;
    localparam int INDEX_W   = 4;
    localparam int CNT_W     = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int ACC_W     = PROD_W + $clog2(TAPS) + 1;
    localparam int FRAC_BITS = 15;
    localparam int S_TDATA_W = 40;

    // Item kinds carried on s_tuser.
    localparam logic ACT_SAMPLE = 1'b0;
    localparam logic ACT_COEF   = 1'b1;

    // Controls that every cell of the history chain sees in one cycle.
    typedef struct packed {
        logic shift;
        logic rotate;
        logic coef_we;
    } cell_ctrl_t;

    // Controls of the shared multiply-accumulate unit.
    typedef struct packed {
        logic clear;
        logic mul_en;
    } mac_ctrl_t;

endpackage

>>> hdl/fcirc_cell.sv
module fcirc_cell
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  fcirc_pkg::cell_ctrl_t                  ctrl,
    input  logic signed [fcirc_pkg::DATA_W-1:0]    shift_sample,
    input  logic signed [fcirc_pkg::DATA_W-1:0]    rot_sample,
    input  logic signed [fcirc_pkg::DATA_W-1:0]    rot_coef,
    input  logic signed [fcirc_pkg::DATA_W-1:0]    coef_value,
    output logic signed [fcirc_pkg::DATA_W-1:0]    sample,
    output logic signed [fcirc_pkg::DATA_W-1:0]    coef
);

    logic signed [fcirc_pkg::DATA_W-1:0] sample_reg;
    logic signed [fcirc_pkg::DATA_W-1:0] sample_next;
    logic signed [fcirc_pkg::DATA_W-1:0] coef_reg;
    logic signed [fcirc_pkg::DATA_W-1:0] coef_next;

    always_comb
    begin
        sample_next = sample_reg;
        coef_next   = coef_reg;
        if (ctrl.shift)
        begin
            sample_next = shift_sample;
        end
        else if (ctrl.rotate)
        begin
            sample_next = rot_sample;
        end
        if (ctrl.coef_we)
        begin
            coef_next = coef_value;
        end
        else if (ctrl.rotate)
        begin
            coef_next = rot_coef;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_reg <= '0;
            coef_reg   <= '0;
        end
        else
        begin
            sample_reg <= sample_next;
            coef_reg   <= coef_next;
        end
    end

    assign sample = sample_reg;
    assign coef   = coef_reg;

endmodule

>>> hdl/fcirc_mac.sv
module fcirc_mac
(
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  fcirc_pkg::mac_ctrl_t                   ctrl,
    input  logic signed [fcirc_pkg::DATA_W-1:0]    mul_a,
    input  logic signed [fcirc_pkg::DATA_W-1:0]    mul_b,
    output logic signed [fcirc_pkg::DATA_W-1:0]    result
);

    localparam int ACC_W  = fcirc_pkg::ACC_W;
    localparam int PROD_W = fcirc_pkg::PROD_W;
    localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
    localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

    logic signed [fcirc_pkg::PROD_W-1:0] prod_reg;
    logic                                prod_valid_reg;
    logic signed [ACC_W-1:0]             acc_reg;
    logic signed [ACC_W-1:0]             acc_next;
    logic signed [ACC_W-1:0]             shifted;

    always_comb
    begin
        acc_next = acc_reg;
        if (ctrl.clear)
        begin
            acc_next = '0;
        end
        else if (prod_valid_reg)
        begin
            acc_next = acc_reg + ACC_W'(prod_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            acc_reg        <= '0;
        end
        else
        begin
            prod_valid_reg <= ctrl.mul_en;
            acc_reg        <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
    end

    // Arithmetic shift gives the floor of the division by 2^15.
    always_comb
    begin
        shifted = acc_reg >>> fcirc_pkg::FRAC_BITS;
        if (shifted > SAT_MAX)
        begin
            result = 16'sh7FFF;
        end
        else if (shifted < SAT_MIN)
        begin
            result = -16'sh8000;
        end
        else
        begin
            result = shifted[fcirc_pkg::DATA_W-1:0];
        end
    end

endmodule

>>> hdl/fir_filter_circular.sv
// Direct-form FIR filter with a row of TAPS history cells and one shared
// multiply-accumulate unit.
// Input channel s_*: tuser selects the item kind (0 = filter one sample,
// 1 = write one coefficient). A coefficient item writes one cell's
// coefficient in the cycle it is accepted and gives no result; an index
// at or above TAPS is ignored.
// A sample item shifts into the newest cell, then the chain rotates its
// samples and coefficients once around, one tap a cycle, past the
// multiplier at cell 0. The block runs through the RUN, DRAIN and FINISH
// states before the result is loaded into the m_* output register.
// Output m_*: filtered sum shifted right by 15 (floor) and saturated.
// The result sits in an output register; while it waits for m_tready the
// block still accepts and computes the next item, and holds a finished
// sum back only until the output register is free.
// Reset clears the sample history, the coefficients and all handshakes.
module fir_filter_circular
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] sample, [19:16] coef_index, [35:20] coef_value, [39:36] zero
    input  logic [fcirc_pkg::S_TDATA_W-1:0]   s_tdata,
    // [0] action
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] filtered
    output logic [fcirc_pkg::DATA_W-1:0]      m_tdata
);

    localparam int TAPS  = fcirc_pkg::TAPS;
    localparam int CNT_W = fcirc_pkg::CNT_W;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_RUN    = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             m_valid_reg;
    logic             m_valid_next;
    logic [fcirc_pkg::DATA_W-1:0] m_data_reg;

    logic                                  s_accept;
    logic                                  out_load;
    logic signed [fcirc_pkg::DATA_W-1:0]   in_sample;
    logic [fcirc_pkg::INDEX_W-1:0]         in_index;
    logic signed [fcirc_pkg::DATA_W-1:0]   in_coef;
    logic signed [fcirc_pkg::DATA_W-1:0]   mac_result;
    logic signed [fcirc_pkg::DATA_W-1:0]   cell_sample [TAPS];
    logic signed [fcirc_pkg::DATA_W-1:0]   cell_coef   [TAPS];
    fcirc_pkg::mac_ctrl_t                  mac_ctrl;

    assign in_sample = s_tdata[15:0];
    assign in_index  = s_tdata[19:16];
    assign in_coef   = s_tdata[35:20];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_FINISH) && (!m_valid_reg || m_tready);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (s_accept && (s_tuser == fcirc_pkg::ACT_SAMPLE))
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(TAPS - 1))
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_valid_next = m_valid_reg;
        if (out_load)
        begin
            m_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            m_data_reg <= mac_result;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Cell 0 holds the newest sample. While running, each cell takes the
    // contents of its upper neighbor, so the taps pass cell 0 in order, newest
    // first, and the ring is back in place when the run ends.
    for (genvar i = 0; i < TAPS; i++)
    begin : g_cell
        localparam int NXT = (i + 1) % TAPS;
        fcirc_pkg::cell_ctrl_t             ctrl;
        logic signed [fcirc_pkg::DATA_W-1:0] prev_sample;

        if (i == 0)
        begin : g_head
            assign prev_sample = in_sample;
        end
        else
        begin : g_body
            assign prev_sample = cell_sample[i-1];
        end

        assign ctrl.shift   = s_accept && (s_tuser == fcirc_pkg::ACT_SAMPLE);
        assign ctrl.rotate  = (state_reg == ST_RUN);
        assign ctrl.coef_we = s_accept && (s_tuser == fcirc_pkg::ACT_COEF) &&
                              (32'(in_index) == 32'(i));

        fcirc_cell u_cell
        (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (ctrl),
            .shift_sample (prev_sample),
            .rot_sample   (cell_sample[NXT]),
            .rot_coef     (cell_coef[NXT]),
            .coef_value   (in_coef),
            .sample       (cell_sample[i]),
            .coef         (cell_coef[i])
        );
    end

    assign mac_ctrl.clear  = s_accept && (s_tuser == fcirc_pkg::ACT_SAMPLE);
    assign mac_ctrl.mul_en = (state_reg == ST_RUN);

    fcirc_mac u_mac
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .mul_a  (cell_coef[0]),
        .mul_b  (cell_sample[0]),
        .result (mac_result)
    );

endmodule

>>> tb/fir_filter_circular_tb.sv
`timescale 1ns / 100ps

module fir_filter_circular_tb;

    localparam int   TAPS       = fcirc_pkg::TAPS;
    localparam int   DATA_W     = fcirc_pkg::DATA_W;
    localparam int   INDEX_W    = fcirc_pkg::INDEX_W;
    localparam int   S_TDATA_W  = fcirc_pkg::S_TDATA_W;
    localparam int   FRAC_BITS  = fcirc_pkg::FRAC_BITS;
    localparam int   LATENCY    = TAPS + 3;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    // [15:0] sample, [19:16] coef_index, [35:20] coef_value, [39:36] zero
    logic [S_TDATA_W-1:0] s_tdata;
    // [0] action
    logic                 s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // [15:0] filtered
    logic [DATA_W-1:0]    m_tdata;

    // Shadow copy of the filter state.
    logic signed [DATA_W-1:0] history [TAPS];
    logic signed [DATA_W-1:0] coefs [TAPS];
    int                       wr_pos;

    logic signed [DATA_W-1:0] expected_filtered [$];
    logic signed [DATA_W-1:0] want;
    int                       failures;
    bit                       sender_idle;
    bit                       ready_idle;
    int                       hold_cycles;

    fir_filter_circular dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #6 clk = ~clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    // Q1.15 value with the field extremes and zero showing up often.
    function automatic logic [DATA_W-1:0] rand_q15();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h8000;
        if (r == 1)
            return 16'h7FFF;
        if (r == 2)
            return 16'h0000;
        return DATA_W'($urandom);
    endfunction

    // Small coefficients keep many sums out of saturation.
    function automatic logic [DATA_W-1:0] rand_coef();
        int v;
        if ($urandom_range(0, 1) == 0)
            return rand_q15();
        v = $urandom_range(0, 4095) - 2048;
        return DATA_W'(v);
    endfunction

    function automatic logic signed [DATA_W-1:0] filter_sample(
        input logic signed [DATA_W-1:0] s);
        longint acc;
        longint q;
        int     p;
        acc = 0;
        history[wr_pos] = s;
        wr_pos = (wr_pos + 1) % TAPS;
        p = wr_pos;
        for (int n = 0; n < TAPS; n++)
        begin
            p = (p == 0) ? TAPS - 1 : p - 1;
            acc += longint'(coefs[n]) * longint'(history[p]);
        end
        q = acc >>> FRAC_BITS;
        if (q > 32767)
            q = 32767;
        if (q < -32768)
            q = -32768;
        return DATA_W'(q);
    endfunction

    task automatic send_item(input logic act, input logic [DATA_W-1:0] sample,
                             input logic [INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        int gap;
        gap = sender_idle ? gap_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= {4'b0000, value, idx, sample};
        do
            @(posedge clk);
        while (!s_tready);
        if (act == fcirc_pkg::ACT_COEF)
        begin
            if (idx < TAPS)
                coefs[idx] = value;
        end
        else
        begin
            expected_filtered.push_back(filter_sample(sample));
        end
    endtask

    task automatic send_sample(input logic [DATA_W-1:0] sample);
        send_item(fcirc_pkg::ACT_SAMPLE, sample, INDEX_W'($urandom),
                  DATA_W'($urandom));
    endtask

    task automatic send_coef(input logic [INDEX_W-1:0] idx,
                             input logic [DATA_W-1:0] value);
        send_item(fcirc_pkg::ACT_COEF, DATA_W'($urandom), idx, value);
    endtask

    task automatic send_random_item();
        if ($urandom_range(0, 99) < 15)
            send_coef(INDEX_W'($urandom), rand_coef());
        else
            send_sample(rand_q15());
    endtask

    // With an all-zero table every output is zero, whatever the sample.
    task automatic test_cleared_state();
        send_sample(16'h7FFF);
        send_sample(16'h8000);
    endtask

    // A unit tap at slot 0 checks the floor of the shift on both signs.
    task automatic test_single_tap();
        send_coef(4'd0, 16'h7FFF);
        send_sample(16'h0001);
        send_sample(16'hFFFF);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_coef(4'd15, 16'h8000);
        send_sample(16'h1234);
    endtask

    task automatic test_saturation();
        send_coef(4'd0, 16'h8000);
        send_coef(4'd1, 16'h8000);
        send_sample(16'h8000);
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h8000);
    endtask

    task automatic test_random_mix(input int count);
        sender_idle = 1'b1;
        ready_idle  = 1'b1;
        repeat (count) send_random_item();
    endtask

    task automatic test_back_to_back(input int count);
        sender_idle = 1'b0;
        ready_idle  = 1'b0;
        repeat (count) send_random_item();
    endtask

    // The receiver stops for a long while so the block backs up its input.
    task automatic test_output_stall(input int count);
        sender_idle = 1'b0;
        ready_idle  = 1'b1;
        hold_cycles = 400;
        repeat (count) send_random_item();
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_filtered.size() == 0)
            begin
                $error("filtered: unexpected item, actual %0d", $signed(m_tdata));
                failures++;
            end
            else
            begin
                want = expected_filtered.pop_front();
                if (m_tdata !== want)
                begin
                    $error("filtered mismatch: expected %0d, actual %0d",
                           want, $signed(m_tdata));
                    failures++;
                end
            end
        end
    end

    initial
    begin
        int  dur;
        logic lvl;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                lvl = 1'b0;
                dur = hold_cycles;
                hold_cycles = 0;
            end
            else if (!ready_idle)
            begin
                lvl = 1'b1;
                dur = 1;
            end
            else
            begin
                lvl = ($urandom_range(0, 3) != 0);
                dur = lvl ? $urandom_range(1, 20) : gap_len() + 1;
            end
            m_tready <= lvl;
            repeat (dur) @(posedge clk);
        end
    end

    initial
    begin
        #12_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = fcirc_pkg::ACT_SAMPLE;
        failures    = 0;
        sender_idle = 1'b0;
        ready_idle  = 1'b0;
        hold_cycles = 0;
        wr_pos      = 0;
        for (int i = 0; i < TAPS; i++)
        begin
            history[i] = '0;
            coefs[i]   = '0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        test_cleared_state();
        test_single_tap();
        test_saturation();
        test_random_mix(640);
        test_back_to_back(180);
        test_output_stall(120);

        s_tvalid <= 1'b0;
        ready_idle = 1'b0;
        wait (expected_filtered.size() == 0);
        repeat (LATENCY + 8) @(posedge clk);
        if (expected_filtered.size() != 0)
        begin
            $error("filtered: %0d expected items never arrived", expected_filtered.size());
            failures++;
        end
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
hdl/fcirc_pkg.sv
hdl/fcirc_cell.sv
hdl/fcirc_mac.sv
hdl/fir_filter_circular.sv
tb/fir_filter_circular_tb.sv
